// ----- rtl/stls_pkg.sv -----
// Shared types, codes and constants for the stair leg sequencer.
package stls_pkg;

  localparam int unsigned UP_REAR_HOLD_US_DEF    = 200000;
  localparam int unsigned DOWN_FRONT_HOLD_US_DEF = 1000000;
  localparam int unsigned DOWN_LOWER_HOLD_US_DEF = 1000000;

  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 104;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_1    = 3'd1,
    PH_2    = 3'd2,
    PH_3    = 3'd3,
    PH_4    = 3'd4
  } phase_t;

  localparam logic DIR_UP   = 1'b0;
  localparam logic DIR_DOWN = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_SPEED   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UP_READY_SPEED  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UP_CLOSE_SPEED  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DOWN_CLOSE_SPEED = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIST_THRESHOLD  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TOL      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_HOME_TOL        = 3'd6;

  localparam logic [9:0] SETTLE_TOL_RST = 10'd100;
  localparam logic [9:0] HOME_TOL_RST   = 10'd80;

  // setpoints in milliradians
  localparam logic signed [13:0] MR_ZERO = 14'sd0;
  localparam logic signed [13:0] MR_PI   = 14'sd3142;
  localparam logic signed [13:0] MR_256  = 14'sd4468;
  localparam logic signed [13:0] MR_104  = 14'sd1815;
  localparam logic signed [13:0] MR_102  = 14'sd1780;
  localparam logic signed [13:0] MR_100  = 14'sd1745;
  localparam logic signed [13:0] MR_90   = 14'sd1571;
  localparam logic signed [13:0] MR_270  = 14'sd4712;

  localparam logic [7:0] ACCEL_CLIMB = 8'd15;
  localparam logic [7:0] ACCEL_RISE  = 8'd50;

  localparam logic [12:0] DRIVE_NORMAL = 13'd5000;
  localparam logic [12:0] DRIVE_SOFT   = 13'd2000;
  localparam logic [12:0] DRIVE_HARD   = 13'd7000;
  localparam logic [12:0] DRIVE_LOWER  = 13'd600;

  // photo switch bits
  localparam int SW_FRONT_RETRACT = 0;
  localparam int SW_FRONT_EXTEND  = 1;
  localparam int SW_REAR_RETRACT  = 2;
  localparam int SW_REAR_EXTEND   = 3;

  typedef struct packed {
    logic [15:0] default_speed;
    logic [15:0] up_ready_speed;
    logic [15:0] up_close_speed;
    logic [15:0] down_close_speed;
    logic [15:0] distance_threshold;
    logic [9:0]  settle_tolerance;
    logic [9:0]  home_tolerance;
  } cfg_t;

  typedef struct packed {
    logic               up_start;
    logic               down_start;
    logic               wait_start;
    logic [15:0]        distance;
    logic [3:0]         photo_switches;
    logic signed [13:0] front_left_pos;
    logic signed [13:0] front_right_pos;
    logic signed [13:0] rear_left_pos;
    logic signed [13:0] rear_right_pos;
    logic [31:0]        time_us;
  } item_t;

  typedef struct packed {
    phase_t             phase;
    logic               direction;
    logic               req_dir;
    logic               wait_pending;
    logic [31:0]        start_time;
    logic signed [13:0] fl_target;
    logic signed [13:0] fr_target;
    logic signed [13:0] rl_target;
    logic signed [13:0] rr_target;
    logic [7:0]         accel;
  } state_t;

  typedef struct packed {
    logic [2:0]         phase;
    logic               direction;
    logic signed [13:0] front_left_target;
    logic signed [13:0] front_right_target;
    logic signed [13:0] rear_left_target;
    logic signed [13:0] rear_right_target;
    logic [15:0]        speed_limit;
    logic [7:0]         accel_limit;
    logic [12:0]        drive_limit;
    logic               wait_continue;
  } result_t;

  // |x| < tol for a small signed value
  function automatic logic within_tol(input logic signed [15:0] x, input logic [9:0] tol);
    logic [15:0] mag;
    mag = x[15] ? 16'(-x) : 16'(x);
    return mag < {6'd0, tol};
  endfunction

endpackage

// ----- rtl/stair_leg_sequencer.sv -----
// Top level of the stair leg sequencer: input register, phase state, result register.
//
//   channel  dir  handshake           payload
//   s_*      in   s_tvalid/s_tready   s_tdata, one control tick
//   m_*      out  m_tvalid/m_tready   m_tdata, one result per tick
//   cfg_*    in   cfg_we              cfg_index, cfg_data
//
// One tick per cycle sustained while results are taken; a tick's result is loaded into
// the result register after the input register, through the phase logic.
// The phase state is updated as a tick moves from input to result register.
// rst is synchronous and returns phase, events, targets and config to reset values.
// A stalled result holds the result register; the input register still takes
// one more tick, then s_tready drops until the result is taken.
module stair_leg_sequencer #(
  parameter int unsigned UP_REAR_HOLD_US    = stls_pkg::UP_REAR_HOLD_US_DEF,
  parameter int unsigned DOWN_FRONT_HOLD_US = stls_pkg::DOWN_FRONT_HOLD_US_DEF,
  parameter int unsigned DOWN_LOWER_HOLD_US = stls_pkg::DOWN_LOWER_HOLD_US_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // up_start, down_start, wait_start, distance, photo_switches, front_left_pos,
  // front_right_pos, rear_left_pos, rear_right_pos, time_us, zero pad
  input  logic [stls_pkg::IN_DATA_W-1:0]    s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // phase, direction, front_left_target, front_right_target, rear_left_target,
  // rear_right_target, speed_limit, accel_limit, drive_limit, wait_continue, zero pad
  output logic [stls_pkg::OUT_DATA_W-1:0]   m_tdata,
  input  logic                              cfg_we,
  input  logic [stls_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [stls_pkg::CFG_DATA_W-1:0]   cfg_data
);

  stls_pkg::cfg_t    cfg;
  stls_pkg::item_t   in_item;
  stls_pkg::item_t   in_q;
  logic              in_valid;
  stls_pkg::state_t  st;
  stls_pkg::state_t  st_next;
  stls_pkg::result_t res;
  stls_pkg::result_t res_q;
  logic              out_ready;
  logic              advance;

  assign in_item.up_start        = s_tdata[0];
  assign in_item.down_start      = s_tdata[1];
  assign in_item.wait_start      = s_tdata[2];
  assign in_item.distance        = s_tdata[18:3];
  assign in_item.photo_switches  = s_tdata[22:19];
  assign in_item.front_left_pos  = s_tdata[36:23];
  assign in_item.front_right_pos = s_tdata[50:37];
  assign in_item.rear_left_pos   = s_tdata[64:51];
  assign in_item.rear_right_pos  = s_tdata[78:65];
  assign in_item.time_us         = s_tdata[110:79];

  assign out_ready = !m_tvalid || m_tready;
  assign advance   = in_valid && out_ready;
  assign s_tready  = !in_valid || out_ready;

  stls_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  stls_step #(
    .UP_REAR_HOLD_US    (UP_REAR_HOLD_US),
    .DOWN_FRONT_HOLD_US (DOWN_FRONT_HOLD_US),
    .DOWN_LOWER_HOLD_US (DOWN_LOWER_HOLD_US)
  ) u_step (
    .cfg     (cfg),
    .st      (st),
    .item    (in_q),
    .st_next (st_next),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_q <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase        <= stls_pkg::PH_IDLE;
      st.direction    <= stls_pkg::DIR_UP;
      st.req_dir      <= stls_pkg::DIR_UP;
      st.wait_pending <= 1'b0;
      st.start_time   <= '0;
      st.fl_target    <= stls_pkg::MR_ZERO;
      st.fr_target    <= stls_pkg::MR_ZERO;
      st.rl_target    <= stls_pkg::MR_ZERO;
      st.rr_target    <= stls_pkg::MR_ZERO;
      st.accel        <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign m_tdata = {6'd0,
                    res_q.wait_continue,
                    res_q.drive_limit,
                    res_q.accel_limit,
                    res_q.speed_limit,
                    res_q.rear_right_target,
                    res_q.rear_left_target,
                    res_q.front_right_target,
                    res_q.front_left_target,
                    res_q.direction,
                    res_q.phase};

endmodule

// ----- rtl/stls_cfg.sv -----
// Configuration register file of the stair leg sequencer.
module stls_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [stls_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [stls_pkg::CFG_DATA_W-1:0]     cfg_data,
  output stls_pkg::cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.default_speed      <= '0;
      cfg.up_ready_speed     <= '0;
      cfg.up_close_speed     <= '0;
      cfg.down_close_speed   <= '0;
      cfg.distance_threshold <= '0;
      cfg.settle_tolerance   <= stls_pkg::SETTLE_TOL_RST;
      cfg.home_tolerance     <= stls_pkg::HOME_TOL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        stls_pkg::CFG_DEFAULT_SPEED:    cfg.default_speed      <= cfg_data;
        stls_pkg::CFG_UP_READY_SPEED:   cfg.up_ready_speed     <= cfg_data;
        stls_pkg::CFG_UP_CLOSE_SPEED:   cfg.up_close_speed     <= cfg_data;
        stls_pkg::CFG_DOWN_CLOSE_SPEED: cfg.down_close_speed   <= cfg_data;
        stls_pkg::CFG_DIST_THRESHOLD:   cfg.distance_threshold <= cfg_data;
        stls_pkg::CFG_SETTLE_TOL:       cfg.settle_tolerance   <= cfg_data[9:0];
        stls_pkg::CFG_HOME_TOL:         cfg.home_tolerance     <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/stls_step.sv -----
// Per-tick phase logic: next sequencer state and the result of one tick.
module stls_step #(
  parameter int unsigned UP_REAR_HOLD_US    = stls_pkg::UP_REAR_HOLD_US_DEF,
  parameter int unsigned DOWN_FRONT_HOLD_US = stls_pkg::DOWN_FRONT_HOLD_US_DEF,
  parameter int unsigned DOWN_LOWER_HOLD_US = stls_pkg::DOWN_LOWER_HOLD_US_DEF
) (
  input  stls_pkg::cfg_t    cfg,
  input  stls_pkg::state_t  st,
  input  stls_pkg::item_t   item,
  output stls_pkg::state_t  st_next,
  output stls_pkg::result_t res
);

  localparam logic [31:0] UP_REAR_HOLD    = 32'(UP_REAR_HOLD_US);
  localparam logic [31:0] DOWN_FRONT_HOLD = 32'(DOWN_FRONT_HOLD_US);
  localparam logic [31:0] DOWN_LOWER_HOLD = 32'(DOWN_LOWER_HOLD_US);

  logic        start;
  logic [31:0] elapsed;
  logic        home;
  logic        settled;
  logic [15:0] speed;
  logic [12:0] drive;
  logic        cont;

  assign start   = item.up_start | item.down_start;
  assign elapsed = item.time_us - st.start_time;

  assign home = stls_pkg::within_tol(16'(item.front_left_pos), cfg.home_tolerance) &&
                stls_pkg::within_tol(16'(item.front_right_pos), cfg.home_tolerance) &&
                stls_pkg::within_tol(16'(item.rear_left_pos), cfg.home_tolerance) &&
                stls_pkg::within_tol(16'(item.rear_right_pos), cfg.home_tolerance);

  assign settled =
    stls_pkg::within_tol(16'(item.rear_left_pos) + 16'(stls_pkg::MR_PI), cfg.settle_tolerance) &&
    stls_pkg::within_tol(16'(item.rear_right_pos) - 16'(stls_pkg::MR_PI), cfg.settle_tolerance);

  always_comb begin
    st_next = st;
    speed   = cfg.default_speed;
    drive   = stls_pkg::DRIVE_NORMAL;
    cont    = 1'b0;

    if (item.up_start) begin
      st_next.req_dir = stls_pkg::DIR_UP;
    end else if (item.down_start) begin
      st_next.req_dir = stls_pkg::DIR_DOWN;
    end else if (item.wait_start) begin
      st_next.wait_pending = 1'b1;
    end

    if (st_next.wait_pending && st.phase == stls_pkg::PH_IDLE && home) begin
      cont                 = 1'b1;
      st_next.wait_pending = 1'b0;
    end

    if (st.phase == stls_pkg::PH_IDLE) begin
      st_next.direction = st_next.req_dir;
    end

    case (st.phase)
      stls_pkg::PH_IDLE: begin
        st_next.fl_target = stls_pkg::MR_ZERO;
        st_next.fr_target = stls_pkg::MR_ZERO;
        st_next.rl_target = stls_pkg::MR_ZERO;
        st_next.rr_target = stls_pkg::MR_ZERO;
        if (start) st_next.phase = stls_pkg::PH_1;
      end
      stls_pkg::PH_1: begin
        if (st.direction == stls_pkg::DIR_UP) begin
          speed             = cfg.up_ready_speed;
          st_next.fl_target = stls_pkg::MR_256;
          st_next.fr_target = stls_pkg::MR_104;
          st_next.rl_target = -stls_pkg::MR_102;
          st_next.rr_target = stls_pkg::MR_102;
          if (item.distance < cfg.distance_threshold) st_next.phase = stls_pkg::PH_2;
        end else begin
          speed             = cfg.down_close_speed;
          st_next.fl_target = stls_pkg::MR_90;
          st_next.fr_target = stls_pkg::MR_270;
          st_next.rl_target = -stls_pkg::MR_90;
          st_next.rr_target = stls_pkg::MR_90;
          if (item.photo_switches[stls_pkg::SW_REAR_EXTEND]) st_next.phase = stls_pkg::PH_2;
        end
      end
      stls_pkg::PH_2: begin
        if (st.direction == stls_pkg::DIR_UP) begin
          drive             = stls_pkg::DRIVE_SOFT;
          speed             = cfg.up_close_speed;
          st_next.accel     = stls_pkg::ACCEL_CLIMB;
          st_next.fl_target = stls_pkg::MR_PI;
          st_next.fr_target = stls_pkg::MR_PI;
          st_next.rl_target = -stls_pkg::MR_PI;
          st_next.rr_target = stls_pkg::MR_PI;
          if (!item.photo_switches[stls_pkg::SW_FRONT_RETRACT] && settled) begin
            st_next.phase = stls_pkg::PH_3;
          end
        end else begin
          drive             = stls_pkg::DRIVE_HARD;
          speed             = cfg.down_close_speed;
          st_next.rl_target = -stls_pkg::MR_PI;
          st_next.rr_target = stls_pkg::MR_PI;
          if (item.photo_switches[stls_pkg::SW_FRONT_EXTEND]) begin
            st_next.phase      = stls_pkg::PH_3;
            st_next.start_time = item.time_us;
          end
        end
      end
      stls_pkg::PH_3: begin
        drive = stls_pkg::DRIVE_HARD;
        if (st.direction == stls_pkg::DIR_UP) begin
          speed             = cfg.up_close_speed;
          st_next.accel     = stls_pkg::ACCEL_RISE;
          st_next.fl_target = stls_pkg::MR_90;
          st_next.fr_target = stls_pkg::MR_270;
          if (!item.photo_switches[stls_pkg::SW_REAR_RETRACT]) begin
            st_next.phase      = stls_pkg::PH_4;
            st_next.start_time = item.time_us;
          end
        end else begin
          speed             = cfg.down_close_speed;
          st_next.fl_target = stls_pkg::MR_PI;
          st_next.fr_target = stls_pkg::MR_PI;
          if (elapsed > DOWN_FRONT_HOLD) begin
            st_next.phase      = stls_pkg::PH_4;
            st_next.start_time = item.time_us;
          end
        end
      end
      stls_pkg::PH_4: begin
        if (st.direction == stls_pkg::DIR_UP) begin
          drive             = stls_pkg::DRIVE_HARD;
          speed             = cfg.up_close_speed;
          st_next.rl_target = stls_pkg::MR_ZERO;
          st_next.rr_target = stls_pkg::MR_ZERO;
          if (elapsed > UP_REAR_HOLD) st_next.phase = stls_pkg::PH_IDLE;
        end else begin
          drive             = stls_pkg::DRIVE_LOWER;
          speed             = cfg.down_close_speed;
          st_next.fl_target = stls_pkg::MR_256;
          st_next.fr_target = stls_pkg::MR_104;
          st_next.rl_target = -stls_pkg::MR_100;
          st_next.rr_target = stls_pkg::MR_100;
          if (elapsed > DOWN_LOWER_HOLD) st_next.phase = stls_pkg::PH_IDLE;
        end
      end
      default: begin
        st_next.phase = stls_pkg::PH_IDLE;
      end
    endcase
  end

  assign res.phase              = st_next.phase;
  assign res.direction          = st_next.direction;
  assign res.front_left_target  = st_next.fl_target;
  assign res.front_right_target = st_next.fr_target;
  assign res.rear_left_target   = st_next.rl_target;
  assign res.rear_right_target  = st_next.rr_target;
  assign res.speed_limit        = speed;
  assign res.accel_limit        = st_next.accel;
  assign res.drive_limit        = drive;
  assign res.wait_continue      = cont;

endmodule

// ----- rtl/stls_chk.sv -----
// Port-level checker for the stair leg sequencer, bound to the top level.
module stls_chk (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tready,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [stls_pkg::OUT_DATA_W-1:0]   m_tdata
);

  logic [2:0]  out_phase;
  logic [7:0]  out_accel;
  logic [12:0] out_drive;

  assign out_phase = m_tdata[2:0];
  assign out_accel = m_tdata[83:76];
  assign out_drive = m_tdata[96:84];

  a_reset_clear: assert property (@(posedge clk) rst |=> s_tready && !m_tvalid)
    else $error("block not ready or output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> out_phase <= 3'd4)
    else $error("phase out of range");

  a_drive_codes: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> out_drive == stls_pkg::DRIVE_NORMAL || out_drive == stls_pkg::DRIVE_SOFT ||
                 out_drive == stls_pkg::DRIVE_HARD || out_drive == stls_pkg::DRIVE_LOWER)
    else $error("drive limit not a known setting");

  a_accel_codes: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> out_accel == 8'd0 || out_accel == stls_pkg::ACCEL_CLIMB ||
                 out_accel == stls_pkg::ACCEL_RISE)
    else $error("accel limit not a known setting");

endmodule

bind stair_leg_sequencer stls_chk u_stls_chk (.*);

// ----- verif/stair_leg_sequencer_tb.sv -----
// Self-checking testbench for stair_leg_sequencer: directed phase walks, then biased random ticks.
module stair_leg_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 250000;
  localparam logic [stls_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [stls_pkg::IN_DATA_W-1:0]  s_tdata = '0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [stls_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                            cfg_we = 1'b0;
  logic [stls_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [stls_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  stair_leg_sequencer i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // sequencer state as the testbench sees it
  stls_pkg::cfg_t     cfg_copy;
  logic [2:0]         ph_q;
  logic               dir_q;
  logic               req_dir_q;
  logic               wait_q;
  logic [31:0]        start_q;
  logic signed [13:0] leg_sp[4];
  logic [7:0]         accel_q;
  logic [31:0]        now_us;

  stls_pkg::result_t setpoint_q[$];
  int      err_count = 0;
  bit      calm = 1'b0;
  bit      rx_bursty = 1'b1;
  bit      tx_bursty = 1'b1;
  int      stall_left = 0;

  function automatic logic [stls_pkg::IN_DATA_W-1:0] pack_tick(input stls_pkg::item_t it);
    logic [stls_pkg::IN_DATA_W-1:0] d;
    d = '0;
    d[0]      = it.up_start;
    d[1]      = it.down_start;
    d[2]      = it.wait_start;
    d[18:3]   = it.distance;
    d[22:19]  = it.photo_switches;
    d[36:23]  = it.front_left_pos;
    d[50:37]  = it.front_right_pos;
    d[64:51]  = it.rear_left_pos;
    d[78:65]  = it.rear_right_pos;
    d[110:79] = it.time_us;
    return d;
  endfunction

  function automatic stls_pkg::result_t unpack_result(
      input logic [stls_pkg::OUT_DATA_W-1:0] d);
    stls_pkg::result_t r;
    r.phase              = d[2:0];
    r.direction          = d[3];
    r.front_left_target  = d[17:4];
    r.front_right_target = d[31:18];
    r.rear_left_target   = d[45:32];
    r.rear_right_target  = d[59:46];
    r.speed_limit        = d[75:60];
    r.accel_limit        = d[83:76];
    r.drive_limit        = d[96:84];
    r.wait_continue      = d[97];
    return r;
  endfunction

  function automatic stls_pkg::item_t tick(input bit up, input bit dn, input bit wt,
                                           input int range_val, input int sw, input int fl,
                                           input int fr, input int rl, input int rr,
                                           input logic [31:0] t);
    stls_pkg::item_t it;
    it.up_start        = up;
    it.down_start      = dn;
    it.wait_start      = wt;
    it.distance        = range_val[15:0];
    it.photo_switches  = sw[3:0];
    it.front_left_pos  = fl[13:0];
    it.front_right_pos = fr[13:0];
    it.rear_left_pos   = rl[13:0];
    it.rear_right_pos  = rr[13:0];
    it.time_us         = t;
    return it;
  endfunction

  function automatic bit near(input int x, input int tol);
    return ((x < 0) ? -x : x) < tol;
  endfunction

  task automatic aim_legs(input logic signed [13:0] fl, input logic signed [13:0] fr,
                          input logic signed [13:0] rl, input logic signed [13:0] rr);
    leg_sp[0] = fl;
    leg_sp[1] = fr;
    leg_sp[2] = rl;
    leg_sp[3] = rr;
  endtask

  task automatic sequence_tick(input stls_pkg::item_t it, output stls_pkg::result_t r);
    int          p[4];
    int          ht;
    int          st;
    logic [31:0] elapsed;
    logic        start_ev;
    logic        release_ev;
    logic [15:0] speed;
    logic [12:0] drive;
    p[0] = int'($signed(it.front_left_pos));
    p[1] = int'($signed(it.front_right_pos));
    p[2] = int'($signed(it.rear_left_pos));
    p[3] = int'($signed(it.rear_right_pos));
    ht = int'(cfg_copy.home_tolerance);
    st = int'(cfg_copy.settle_tolerance);
    elapsed = it.time_us - start_q;
    start_ev = 1'b0;
    release_ev = 1'b0;

    if (it.up_start) begin
      start_ev = 1'b1;
      req_dir_q = stls_pkg::DIR_UP;
    end else if (it.down_start) begin
      start_ev = 1'b1;
      req_dir_q = stls_pkg::DIR_DOWN;
    end else if (it.wait_start) begin
      wait_q = 1'b1;
    end

    if (wait_q && ph_q == stls_pkg::PH_IDLE && near(p[0], ht) && near(p[1], ht) &&
        near(p[2], ht) && near(p[3], ht)) begin
      release_ev = 1'b1;
      wait_q = 1'b0;
    end

    if (ph_q == stls_pkg::PH_IDLE) dir_q = req_dir_q;

    speed = cfg_copy.default_speed;
    drive = stls_pkg::DRIVE_NORMAL;

    if (ph_q == stls_pkg::PH_IDLE) begin
      aim_legs(stls_pkg::MR_ZERO, stls_pkg::MR_ZERO, stls_pkg::MR_ZERO, stls_pkg::MR_ZERO);
      if (start_ev) ph_q = stls_pkg::PH_1;
    end else if (ph_q > stls_pkg::PH_4) begin
      ph_q = stls_pkg::PH_IDLE;
    end else if (dir_q == stls_pkg::DIR_UP) begin
      case (ph_q)
        stls_pkg::PH_1: begin
          speed = cfg_copy.up_ready_speed;
          aim_legs(stls_pkg::MR_256, stls_pkg::MR_104, -stls_pkg::MR_102, stls_pkg::MR_102);
          if (it.distance < cfg_copy.distance_threshold) ph_q = stls_pkg::PH_2;
        end
        stls_pkg::PH_2: begin
          drive = stls_pkg::DRIVE_SOFT;
          speed = cfg_copy.up_close_speed;
          accel_q = stls_pkg::ACCEL_CLIMB;
          aim_legs(stls_pkg::MR_PI, stls_pkg::MR_PI, -stls_pkg::MR_PI, stls_pkg::MR_PI);
          if (!it.photo_switches[stls_pkg::SW_FRONT_RETRACT] &&
              near(p[2] + int'(stls_pkg::MR_PI), st) &&
              near(p[3] - int'(stls_pkg::MR_PI), st))
            ph_q = stls_pkg::PH_3;
        end
        stls_pkg::PH_3: begin
          drive = stls_pkg::DRIVE_HARD;
          speed = cfg_copy.up_close_speed;
          accel_q = stls_pkg::ACCEL_RISE;
          leg_sp[0] = stls_pkg::MR_90;
          leg_sp[1] = stls_pkg::MR_270;
          if (!it.photo_switches[stls_pkg::SW_REAR_RETRACT]) begin
            ph_q = stls_pkg::PH_4;
            start_q = it.time_us;
          end
        end
        default: begin
          drive = stls_pkg::DRIVE_HARD;
          speed = cfg_copy.up_close_speed;
          leg_sp[2] = stls_pkg::MR_ZERO;
          leg_sp[3] = stls_pkg::MR_ZERO;
          if (elapsed > stls_pkg::UP_REAR_HOLD_US_DEF) ph_q = stls_pkg::PH_IDLE;
        end
      endcase
    end else begin
      speed = cfg_copy.down_close_speed;
      case (ph_q)
        stls_pkg::PH_1: begin
          aim_legs(stls_pkg::MR_90, stls_pkg::MR_270, -stls_pkg::MR_90, stls_pkg::MR_90);
          if (it.photo_switches[stls_pkg::SW_REAR_EXTEND]) ph_q = stls_pkg::PH_2;
        end
        stls_pkg::PH_2: begin
          drive = stls_pkg::DRIVE_HARD;
          leg_sp[2] = -stls_pkg::MR_PI;
          leg_sp[3] = stls_pkg::MR_PI;
          if (it.photo_switches[stls_pkg::SW_FRONT_EXTEND]) begin
            ph_q = stls_pkg::PH_3;
            start_q = it.time_us;
          end
        end
        stls_pkg::PH_3: begin
          drive = stls_pkg::DRIVE_HARD;
          leg_sp[0] = stls_pkg::MR_PI;
          leg_sp[1] = stls_pkg::MR_PI;
          if (elapsed > stls_pkg::DOWN_FRONT_HOLD_US_DEF) begin
            ph_q = stls_pkg::PH_4;
            start_q = it.time_us;
          end
        end
        default: begin
          drive = stls_pkg::DRIVE_LOWER;
          aim_legs(stls_pkg::MR_256, stls_pkg::MR_104, -stls_pkg::MR_100, stls_pkg::MR_100);
          if (elapsed > stls_pkg::DOWN_LOWER_HOLD_US_DEF) ph_q = stls_pkg::PH_IDLE;
        end
      endcase
    end

    r.phase              = ph_q;
    r.direction          = dir_q;
    r.front_left_target  = leg_sp[0];
    r.front_right_target = leg_sp[1];
    r.rear_left_target   = leg_sp[2];
    r.rear_right_target  = leg_sp[3];
    r.speed_limit        = speed;
    r.accel_limit        = accel_q;
    r.drive_limit        = drive;
    r.wait_continue      = release_ev;
  endtask

  task automatic report_error(input string what);
    $display("ERROR at %0t: %s", $time, what);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_error($sformatf("%s got %h want %h", name, got, want));
  endtask

  task automatic check_result(input logic [stls_pkg::OUT_DATA_W-1:0] d);
    stls_pkg::result_t got;
    stls_pkg::result_t want;
    got = unpack_result(d);
    if (setpoint_q.size() == 0) begin
      report_error("result transfer with nothing pending");
    end else begin
      want = setpoint_q.pop_front();
      check_field("phase", got.phase, want.phase);
      check_field("direction", got.direction, want.direction);
      check_field("front_left_target", got.front_left_target, want.front_left_target);
      check_field("front_right_target", got.front_right_target, want.front_right_target);
      check_field("rear_left_target", got.rear_left_target, want.rear_left_target);
      check_field("rear_right_target", got.rear_right_target, want.rear_right_target);
      check_field("speed_limit", got.speed_limit, want.speed_limit);
      check_field("accel_limit", got.accel_limit, want.accel_limit);
      check_field("drive_limit", got.drive_limit, want.drive_limit);
      check_field("wait_continue", got.wait_continue, want.wait_continue);
    end
  endtask

  // result side: check every transfer, stall in bursts
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_result(m_tdata);
    if ($urandom_range(0, 99) == 0) rx_bursty = !rx_bursty;
    if (calm) begin
      m_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (rx_bursty && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 10);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("stair_leg_sequencer_tb: FAIL");
    $finish;
  end

  task automatic send_tick(input stls_pkg::item_t it);
    stls_pkg::result_t r;
    s_tvalid <= 1'b1;
    s_tdata  <= pack_tick(it);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sequence_tick(it, r);
    setpoint_q.push_back(r);
  endtask

  task automatic idle_sender(input int n);
    s_tvalid <= 1'b0;
    s_tdata  <= {$urandom, $urandom, $urandom, $urandom};
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (setpoint_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [stls_pkg::CFG_IDX_W-1:0] idx,
                           input logic [stls_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      stls_pkg::CFG_DEFAULT_SPEED:    cfg_copy.default_speed = val;
      stls_pkg::CFG_UP_READY_SPEED:   cfg_copy.up_ready_speed = val;
      stls_pkg::CFG_UP_CLOSE_SPEED:   cfg_copy.up_close_speed = val;
      stls_pkg::CFG_DOWN_CLOSE_SPEED: cfg_copy.down_close_speed = val;
      stls_pkg::CFG_DIST_THRESHOLD:   cfg_copy.distance_threshold = val;
      stls_pkg::CFG_SETTLE_TOL:       cfg_copy.settle_tolerance = val[9:0];
      stls_pkg::CFG_HOME_TOL:         cfg_copy.home_tolerance = val[9:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [15:0] dflt, input logic [15:0] ready,
                                input logic [15:0] up_close, input logic [15:0] down_close,
                                input logic [15:0] thr, input logic [15:0] settle,
                                input logic [15:0] home);
    drain_results();
    write_reg(stls_pkg::CFG_DEFAULT_SPEED, dflt);
    write_reg(stls_pkg::CFG_UP_READY_SPEED, ready);
    write_reg(stls_pkg::CFG_UP_CLOSE_SPEED, up_close);
    write_reg(stls_pkg::CFG_DOWN_CLOSE_SPEED, down_close);
    write_reg(stls_pkg::CFG_DIST_THRESHOLD, thr);
    write_reg(stls_pkg::CFG_SETTLE_TOL, settle);
    write_reg(stls_pkg::CFG_HOME_TOL, home);
    // out-of-range index must not disturb anything
    write_reg(CFG_UNUSED, $urandom_range(0, 65535));
  endtask

  // random tick steered toward the exit condition of the current phase
  task automatic random_tick(output stls_pkg::item_t it);
    int          roll;
    int          win;
    int          base;
    int          pos[4];
    logic [3:0]  sw;
    logic [31:0] hold;
    bit          climbing;
    climbing = (dir_q == stls_pkg::DIR_UP);
    it = '0;
    roll = $urandom_range(0, 99);
    if (ph_q == stls_pkg::PH_IDLE) begin
      if (roll < 20) it.up_start = 1'b1;
      else if (roll < 40) it.down_start = 1'b1;
    end else begin
      if (roll < 3) it.up_start = 1'b1;
      else if (roll < 6) it.down_start = 1'b1;
    end
    if ($urandom_range(0, 9) == 0) it.up_start = 1'b1;
    if ($urandom_range(0, 9) == 0) it.down_start = 1'b1;
    if ($urandom_range(0, 7) == 0) it.wait_start = 1'b1;

    if (ph_q == stls_pkg::PH_1 && climbing && cfg_copy.distance_threshold != 0 &&
        $urandom_range(0, 2) != 0)
      it.distance = $urandom_range(0, cfg_copy.distance_threshold - 1);
    else
      it.distance = $urandom_range(0, 65535);

    sw = $urandom_range(0, 15);
    if ($urandom_range(0, 1) == 0) begin
      if (ph_q == stls_pkg::PH_2 && climbing) sw[stls_pkg::SW_FRONT_RETRACT] = 1'b0;
      if (ph_q == stls_pkg::PH_3 && climbing) sw[stls_pkg::SW_REAR_RETRACT] = 1'b0;
      if (ph_q == stls_pkg::PH_1 && !climbing) sw[stls_pkg::SW_REAR_EXTEND] = 1'b1;
      if (ph_q == stls_pkg::PH_2 && !climbing) sw[stls_pkg::SW_FRONT_EXTEND] = 1'b1;
    end
    it.photo_switches = sw;

    win = int'(cfg_copy.home_tolerance);
    if (int'(cfg_copy.settle_tolerance) > win) win = int'(cfg_copy.settle_tolerance);
    win += 40;
    for (int i = 0; i < 4; i++) begin
      base = (ph_q == stls_pkg::PH_IDLE) ? 0 : int'(leg_sp[i]);
      if ($urandom_range(0, 3) == 0)
        pos[i] = $urandom_range(0, 16383);
      else
        pos[i] = base + int'($urandom_range(0, 2 * win)) - win;
    end
    it.front_left_pos  = pos[0][13:0];
    it.front_right_pos = pos[1][13:0];
    it.rear_left_pos   = pos[2][13:0];
    it.rear_right_pos  = pos[3][13:0];

    hold = climbing ? stls_pkg::UP_REAR_HOLD_US_DEF : stls_pkg::DOWN_FRONT_HOLD_US_DEF;
    roll = $urandom_range(0, 99);
    if (roll < 60) now_us += $urandom_range(0, 60000);
    else if (roll < 75) now_us += $urandom_range(0, 1500000);
    else if (roll < 90) now_us = start_q + hold + $urandom_range(0, 1);
    else now_us = $urandom;
    it.time_us = now_us;
  endtask

  task automatic run_random(input int n);
    stls_pkg::item_t it;
    for (int k = 0; k < n; k++) begin
      random_tick(it);
      send_tick(it);
      if ($urandom_range(0, 49) == 0) tx_bursty = !tx_bursty;
      if (!calm && tx_bursty && $urandom_range(0, 3) == 0)
        idle_sender($urandom_range(1, 11));
    end
  endtask

  task automatic test_idle_and_wait();
    send_tick(tick(0, 0, 0, 0, 0, 0, 0, 0, 0, 32'd0));
    send_tick(tick(0, 0, 1, 65535, 15, 79, -79, 79, -79, 32'd100));
    send_tick(tick(0, 0, 1, 0, 0, 80, 0, 0, 0, 32'd200));
    send_tick(tick(0, 0, 0, 0, 0, 8191, -8192, 8191, -8192, 32'hFFFF_FFFF));
    send_tick(tick(0, 0, 0, 0, 0, 0, 0, 0, -79, 32'd0));
  endtask

  task automatic test_climb_sequence();
    apply_settings(16'd1000, 16'd2000, 16'd3000, 16'd4000, 16'd500, 16'd100, 16'd80);
    // all three events together: climb wins
    send_tick(tick(1, 1, 1, 65535, 0, 8191, 8191, -8192, -8192, 32'd1000));
    send_tick(tick(0, 0, 0, 500, 0, 0, 0, 0, 0, 32'd2000));
    send_tick(tick(0, 0, 0, 499, 0, 0, 0, 0, 0, 32'd3000));
    send_tick(tick(0, 0, 0, 0, 1, 0, 0, -3142, 3142, 32'd4000));
    send_tick(tick(0, 0, 0, 0, 0, 0, 0, -3042, 3142, 32'd4500));
    send_tick(tick(0, 0, 0, 0, 14, 0, 0, -3241, 3241, 32'd5000));
    send_tick(tick(0, 0, 0, 0, 4, 0, 0, 0, 0, 32'd6000));
    send_tick(tick(0, 0, 0, 0, 0, 0, 0, 0, 0, 32'd10000));
    send_tick(tick(0, 0, 0, 0, 0, 0, 0, 0, 0, 32'd10000 + stls_pkg::UP_REAR_HOLD_US_DEF));
    send_tick(tick(0, 0, 0, 0, 0, 0, 0, 0, 0, 32'd10001 + stls_pkg::UP_REAR_HOLD_US_DEF));
  endtask

  task automatic test_descend_sequence();
    logic [31:0] t0;
    t0 = 32'hFFFF_0000;
    // wait stays pending through the whole descent
    send_tick(tick(0, 0, 1, 0, 0, 500, 0, 0, 0, 32'd0));
    send_tick(tick(0, 1, 1, 0, 0, 500, 0, 0, 0, 32'd10));
    send_tick(tick(0, 0, 0, 0, 7, 0, 0, 0, 0, 32'd20));
    send_tick(tick(0, 0, 0, 0, 8, 0, 0, 0, 0, 32'd30));
    send_tick(tick(0, 0, 0, 0, 2, 0, 0, 0, 0, t0));
    send_tick(tick(0, 0, 0, 0, 0, 0, 0, 0, 0, t0 + stls_pkg::DOWN_FRONT_HOLD_US_DEF));
    t0 = t0 + stls_pkg::DOWN_FRONT_HOLD_US_DEF + 1;
    send_tick(tick(0, 0, 0, 0, 0, 0, 0, 0, 0, t0));
    send_tick(tick(0, 0, 0, 0, 0, 0, 0, 0, 0, t0 + stls_pkg::DOWN_LOWER_HOLD_US_DEF + 1));
    send_tick(tick(0, 0, 0, 0, 0, 0, 0, 0, 0, t0 + stls_pkg::DOWN_LOWER_HOLD_US_DEF + 2));
  endtask

  task automatic test_mid_settings();
    apply_settings($urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(1000, 60000), $urandom_range(50, 400),
                   $urandom_range(50, 300));
    run_random(125);
  endtask

  task automatic test_max_settings();
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1023, 16'd1023);
    run_random(220);
  endtask

  task automatic test_zero_settings();
    apply_settings('0, '0, '0, '0, '0, '0, '0);
    run_random(60);
  endtask

  task automatic test_masked_settings();
    apply_settings($urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(0, 65535));
    run_random(250);
  endtask

  task automatic test_steady_stream();
    apply_settings($urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(1000, 65535), $urandom_range(100, 1023),
                   $urandom_range(100, 1023));
    run_random(200);
    calm = 1'b1;
    run_random(250);
  endtask

  initial begin
    cfg_copy = '0;
    cfg_copy.settle_tolerance = stls_pkg::SETTLE_TOL_RST;
    cfg_copy.home_tolerance = stls_pkg::HOME_TOL_RST;
    ph_q = stls_pkg::PH_IDLE;
    dir_q = stls_pkg::DIR_UP;
    req_dir_q = stls_pkg::DIR_UP;
    wait_q = 1'b0;
    start_q = '0;
    accel_q = '0;
    for (int i = 0; i < 4; i++) leg_sp[i] = stls_pkg::MR_ZERO;
    now_us = '0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_idle_and_wait();
    test_climb_sequence();
    test_descend_sequence();
    test_mid_settings();
    test_max_settings();
    test_zero_settings();
    test_masked_settings();
    test_mid_settings();
    test_steady_stream();

    drain_results();
    repeat (8) @(posedge clk);
    if (err_count == 0)
      $display("stair_leg_sequencer_tb: PASS");
    else
      $display("stair_leg_sequencer_tb: FAIL");
    $finish;
  end

endmodule
